### design/sla_pkg.sv
// Shared types, constants and helper functions for the four-class slab allocator.
// Depends on nothing; every design file but sla_ram imports this package.
package sla_pkg;

    // Default values for the top-level parameters.
    localparam int DEF_MAX_POOL_BYTES       = 65536;
    localparam int DEF_CHUNKS_PER_CLASS_MAX = 512;

    // Fixed field widths.
    localparam int NUM_CLASSES = 4;
    localparam int CLS_W       = 2;
    localparam int ADDR_W      = 32;
    localparam int SIZE_W      = 16;
    localparam int BYTES_W     = 17;
    localparam int CBYTES_W    = 9;
    localparam int RSIZE_W     = 15;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;

    // Smallest region that an init accepts, and the largest chunk size.
    localparam int MIN_REGION = 32;
    localparam int MAX_CHUNK  = 256;

    typedef enum logic [1:0] {
        REQ_INIT  = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_FREE  = 2'd2,
        REQ_QUERY = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_CHUNK    = 2'd1,
        ST_ADDR_REJECT = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE  = 4'd0,
        CFG_POOL_BYTES = 4'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SETUP,
        S_FILL,
        S_DONE
    } sla_state_t;

    // Chunk size of a class: 32, 64, 128 or 256 bytes.
    function automatic logic [CBYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] cls);
        return CBYTES_W'(32) << cls;
    endfunction

    // log2 of the chunk size of a class.
    function automatic logic [3:0] class_shift(input logic [CLS_W-1:0] cls);
        return 4'd5 + 4'(cls);
    endfunction

    // Bytes needed to move an address up to the next 8-byte boundary.
    function automatic logic [2:0] pad_of(input logic [2:0] low_bits);
        return 3'(3'd0 - low_bits);
    endfunction

endpackage

### design/sla_ifs.sv
// Handshake interfaces for the slab allocator: request, response and config write.
// Depends on sla_pkg for the field widths.
interface sla_req_if import sla_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [SIZE_W-1:0]   req_size;
    logic [ADDR_W-1:0]   req_addr;

    modport source (output valid, req_type, req_size, req_addr, input ready);
    modport sink   (input valid, req_type, req_size, req_addr, output ready);
endinterface

interface sla_rsp_if import sla_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [ADDR_W-1:0]   chunk_addr;
    logic [CBYTES_W-1:0] chunk_bytes;

    modport source (output valid, status, chunk_addr, chunk_bytes, input ready);
    modport sink   (input valid, status, chunk_addr, chunk_bytes, output ready);
endinterface

interface sla_cfg_if import sla_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/sla_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing but its parameters.
module sla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/slab_allocator_four_class.sv
// Top level of the four-class slab allocator: request decode, free-list control
// and the link memory. Depends on sla_pkg, sla_ifs and sla_ram.
//
// Usage:
//   cfg  : write channel; index 0 sets pool_base, index 1 sets pool_bytes. It is
//          always ready. Writes take effect at the next init request.
//   req  : one request per transfer (init, allocate, free, query).
//   rsp  : exactly one result transfer per request, in request order.
// Sequence:
//   Allocate, free, query and a failed init pass through the transfer cycle,
//   where the region match is done and, for an allocate, the head's link is
//   read from the link memory, and an execute cycle that updates the list head
//   and loads the result register. A successful init then runs a setup step for
//   each class, a link write for each chunk and a final step that loads the
//   result.
// Reset:
//   All lists are empty and no init has happened; the link memory needs no
//   clearing, so requests are taken right after reset.
// Stall:
//   A finished result waits in the output register while the next request is
//   taken; that request's result then waits in the execute state, or in the done
//   state for a successful init, until the output register is free.
module slab_allocator_four_class import sla_pkg::*; #(
    parameter int MAX_POOL_BYTES       = DEF_MAX_POOL_BYTES,
    parameter int CHUNKS_PER_CLASS_MAX = DEF_CHUNKS_PER_CLASS_MAX
) (
    input  logic   clk,
    input  logic   rst_n,
    sla_cfg_if.sink   cfg,
    sla_req_if.sink   req,
    sla_rsp_if.source rsp
);

    localparam int LW         = $clog2(CHUNKS_PER_CLASS_MAX + 1);
    localparam int LINK_DEPTH = NUM_CLASSES * CHUNKS_PER_CLASS_MAX;
    localparam int AW         = $clog2(LINK_DEPTH);
    localparam logic [LW-1:0] NULL_LINK = LW'(CHUNKS_PER_CLASS_MAX);
    localparam logic [CLS_W-1:0] LAST_CLASS = CLS_W'(NUM_CLASSES - 1);

    // Flat link memory address of chunk k in class cls.
    function automatic logic [AW-1:0] link_index(input logic [CLS_W-1:0] cls,
                                                 input logic [LW-1:0] k);
        logic [31:0] full;
        full = 32'(cls) * 32'(CHUNKS_PER_CLASS_MAX) + 32'(k);
        return full[AW-1:0];
    endfunction

    // Configuration and allocator state.
    logic [ADDR_W-1:0]  pool_base_reg;
    logic [BYTES_W-1:0] pool_bytes_reg;
    logic [LW-1:0]      heads_reg [NUM_CLASSES];
    logic [ADDR_W-1:0]  start_reg [NUM_CLASSES];
    logic [LW-1:0]      count_reg [NUM_CLASSES];
    logic [RSIZE_W-1:0] rsize_reg;
    logic               built_reg;
    sla_state_t         state_reg;
    sla_state_t         state_next;

    // Decoded request, held for the execute cycle.
    req_type_t          dec_type_reg;
    logic [CLS_W-1:0]   dec_acls_reg;
    logic               dec_afit_reg;
    logic [CLS_W-1:0]   dec_rcls_reg;
    logic               dec_rhit_reg;
    logic [RSIZE_W-1:0] dec_off_reg;

    // Init walk.
    logic [CLS_W-1:0]   icls_reg;
    logic [ADDR_W-1:0]  istart_reg;
    logic [LW-1:0]      k_reg;
    logic [LW-1:0]      n_reg;

    // Result register.
    logic                rsp_valid_reg;
    logic [1:0]          rsp_status_reg;
    logic [ADDR_W-1:0]   rsp_addr_reg;
    logic [CBYTES_W-1:0] rsp_bytes_reg;

    // Link memory ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [LW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [LW-1:0] ram_rdata;

    logic                  accept;
    logic [ADDR_W-1:0]     off_full [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] hit_vec;
    logic [CLS_W-1:0]      rcls;
    logic [CLS_W-1:0]      acls;
    logic                  afit;
    logic                  head_ok;

    logic                  out_free;
    logic                  emit;
    logic [1:0]            emit_status;
    logic [ADDR_W-1:0]     emit_addr;
    logic [CBYTES_W-1:0]   emit_bytes;
    logic                  commit;

    logic [BYTES_W-1:0]    clamp_bytes;
    logic [RSIZE_W-1:0]    rsize_calc;
    logic                  init_small;
    logic                  init_go;

    logic [2:0]            free_pad;
    logic [RSIZE_W-1:0]    free_rel;
    logic [RSIZE_W-1:0]    free_kfull;
    logic [LW-1:0]         free_k;
    logic                  free_ok;
    logic                  free_commit;
    logic                  alloc_commit;

    logic [2:0]            setup_pad;
    logic [RSIZE_W-1:0]    setup_usable;
    logic [RSIZE_W-1:0]    setup_nraw;
    logic [LW-1:0]         setup_n;
    logic                  fill_end;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign commit    = emit && out_free;

    // Region match and class choice on the incoming request.
    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            off_full[c] = req.req_addr - start_reg[c];
            hit_vec[c]  = built_reg && (off_full[c] < ADDR_W'(rsize_reg));
        end
        rcls = '0;
        acls = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (hit_vec[c])
            begin
                rcls = CLS_W'(c);
            end
            if (req.req_size <= SIZE_W'(class_bytes(CLS_W'(c))))
            begin
                acls = CLS_W'(c);
            end
        end
        afit    = req.req_size <= SIZE_W'(MAX_CHUNK);
        head_ok = heads_reg[acls] != NULL_LINK;
    end

    // The head's link is read in the transfer cycle of an allocate.
    assign ram_re    = accept && (req_type_t'(req.req_type) == REQ_ALLOC) && afit && head_ok;
    assign ram_raddr = link_index(acls, heads_reg[acls]);

    // Region size for an init request.
    always_comb
    begin
        if (32'(pool_bytes_reg) > 32'(MAX_POOL_BYTES))
        begin
            clamp_bytes = BYTES_W'(MAX_POOL_BYTES);
        end
        else
        begin
            clamp_bytes = pool_bytes_reg;
        end
        rsize_calc = RSIZE_W'(clamp_bytes >> 2);
        init_small = rsize_calc < RSIZE_W'(MIN_REGION);
    end

    // Free checks: pad, chunk boundary and whole-chunk limit.
    always_comb
    begin
        free_pad   = pad_of(start_reg[dec_rcls_reg][2:0]);
        free_rel   = dec_off_reg - RSIZE_W'(free_pad);
        free_kfull = free_rel >> class_shift(dec_rcls_reg);
        free_k     = LW'(free_kfull);
        free_ok    = dec_rhit_reg
                     && (dec_off_reg >= RSIZE_W'(free_pad))
                     && ((free_rel & RSIZE_W'(class_bytes(dec_rcls_reg) - 1'b1)) == '0)
                     && (32'(free_kfull) < 32'(count_reg[dec_rcls_reg]));
    end

    // Per-class setup of the init walk.
    always_comb
    begin
        setup_pad    = pad_of(istart_reg[2:0]);
        setup_usable = rsize_reg - RSIZE_W'(setup_pad);
        setup_nraw   = setup_usable >> class_shift(icls_reg);
        if (32'(setup_nraw) > 32'(CHUNKS_PER_CLASS_MAX))
        begin
            setup_n = LW'(CHUNKS_PER_CLASS_MAX);
        end
        else
        begin
            setup_n = LW'(setup_nraw);
        end
        fill_end = (k_reg == n_reg - 1'b1);
    end

    // Next state and result selection.
    always_comb
    begin
        state_next  = state_reg;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_addr   = '0;
        emit_bytes  = '0;
        init_go     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (dec_type_reg)
                    REQ_INIT:
                    begin
                        if (init_small)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_NO_CHUNK;
                        end
                        else
                        begin
                            init_go = 1'b1;
                        end
                    end
                    REQ_ALLOC:
                    begin
                        emit = 1'b1;
                        if (dec_afit_reg)
                        begin
                            emit_addr  = start_reg[dec_acls_reg]
                                         + ADDR_W'(pad_of(start_reg[dec_acls_reg][2:0]))
                                         + (ADDR_W'(heads_reg[dec_acls_reg])
                                            << class_shift(dec_acls_reg));
                            emit_bytes = class_bytes(dec_acls_reg);
                        end
                        else
                        begin
                            emit_status = ST_NO_CHUNK;
                        end
                    end
                    REQ_FREE:
                    begin
                        emit = 1'b1;
                        if (!free_ok)
                        begin
                            emit_status = ST_ADDR_REJECT;
                        end
                    end
                    REQ_QUERY:
                    begin
                        emit = 1'b1;
                        if (dec_rhit_reg)
                        begin
                            emit_bytes = class_bytes(dec_rcls_reg);
                        end
                    end
                    default:
                    begin
                        emit = 1'b1;
                    end
                endcase
                if (init_go)
                begin
                    state_next = S_SETUP;
                end
                else if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SETUP:
            begin
                if (setup_n != '0)
                begin
                    state_next = S_FILL;
                end
                else if (icls_reg == LAST_CLASS)
                begin
                    state_next = S_DONE;
                end
            end
            S_FILL:
            begin
                if (fill_end)
                begin
                    state_next = (icls_reg == LAST_CLASS) ? S_DONE : S_SETUP;
                end
            end
            S_DONE:
            begin
                emit = 1'b1;
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign alloc_commit = (state_reg == S_EXEC) && commit
                          && (dec_type_reg == REQ_ALLOC) && dec_afit_reg;
    assign free_commit  = (state_reg == S_EXEC) && commit
                          && (dec_type_reg == REQ_FREE) && free_ok;

    // Link memory writes: a freed chunk links to the old head, the init walk
    // links each chunk to the one below it.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = link_index(dec_rcls_reg, free_k);
        ram_wdata = heads_reg[dec_rcls_reg];
        if (free_commit)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_FILL)
        begin
            ram_we    = 1'b1;
            ram_waddr = link_index(icls_reg, k_reg);
            ram_wdata = (k_reg == '0) ? NULL_LINK : k_reg - 1'b1;
        end
    end

    sla_ram #(
        .WIDTH (LW),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Control state, configuration and list heads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
            built_reg      <= 1'b0;
            pool_base_reg  <= '0;
            pool_bytes_reg <= '0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                heads_reg[c] <= NULL_LINK;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                case (cfg_index_t'(cfg.index))
                    CFG_POOL_BASE:  pool_base_reg  <= cfg.data;
                    CFG_POOL_BYTES: pool_bytes_reg <= BYTES_W'(cfg.data);
                    default:        ;
                endcase
            end
            if (state_reg == S_DONE)
            begin
                built_reg <= 1'b1;
            end
            if (alloc_commit)
            begin
                heads_reg[dec_acls_reg] <= ram_rdata;
            end
            if (free_commit)
            begin
                heads_reg[dec_rcls_reg] <= free_k;
            end
            if (state_reg == S_SETUP)
            begin
                heads_reg[icls_reg] <= (setup_n == '0) ? NULL_LINK : setup_n - 1'b1;
            end
        end
    end

    // Payload registers: decoded request, region table, init walk and result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dec_type_reg <= req_type_t'(req.req_type);
            dec_acls_reg <= acls;
            dec_afit_reg <= afit && head_ok;
            dec_rcls_reg <= rcls;
            dec_rhit_reg <= |hit_vec;
            dec_off_reg  <= RSIZE_W'(off_full[rcls]);
        end
        if (init_go)
        begin
            rsize_reg  <= rsize_calc;
            istart_reg <= pool_base_reg;
            icls_reg   <= '0;
        end
        if (state_reg == S_SETUP)
        begin
            start_reg[icls_reg] <= istart_reg;
            count_reg[icls_reg] <= setup_n;
            n_reg               <= setup_n;
            k_reg               <= '0;
            istart_reg          <= istart_reg + ADDR_W'(rsize_reg);
            if (setup_n == '0)
            begin
                icls_reg <= icls_reg + 1'b1;
            end
        end
        if (state_reg == S_FILL)
        begin
            k_reg <= k_reg + 1'b1;
            if (fill_end)
            begin
                icls_reg <= icls_reg + 1'b1;
            end
        end
        if (commit)
        begin
            rsp_status_reg <= emit_status;
            rsp_addr_reg   <= emit_addr;
            rsp_bytes_reg  <= emit_bytes;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.chunk_addr  = rsp_addr_reg;
    assign rsp.chunk_bytes = rsp_bytes_reg;

endmodule

### design/sla_checker.sv
// Port-level checker for the slab allocator and its bind to the top level.
// Depends on sla_pkg and on the ports of slab_allocator_four_class.
module sla_checker import sla_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [1:0]          rsp_status,
    input logic [ADDR_W-1:0]   rsp_chunk_addr,
    input logic [CBYTES_W-1:0] rsp_chunk_bytes
);

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_chunk_addr) && $stable(rsp_chunk_bytes))
    else $error("stalled result changed");

    // Only one request is in flight: no transfer right after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

    // A failed or rejected request carries no chunk.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_chunk_addr == '0 && rsp_chunk_bytes == '0)
    else $error("failed request returned a chunk");

    // Status is one of the three defined codes and chunk sizes are zero or class sizes.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_NO_CHUNK
            || rsp_status == ST_ADDR_REJECT)
            && (rsp_chunk_bytes == 9'd0 || rsp_chunk_bytes == 9'd32
            || rsp_chunk_bytes == 9'd64 || rsp_chunk_bytes == 9'd128
            || rsp_chunk_bytes == 9'd256))
    else $error("bad status or chunk size");

    // A returned chunk address always comes with its chunk size.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_chunk_addr != '0 |-> rsp_chunk_bytes != '0)
    else $error("chunk address without chunk size");

endmodule

bind slab_allocator_four_class sla_checker u_sla_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_chunk_addr  (rsp.chunk_addr),
    .rsp_chunk_bytes (rsp.chunk_bytes)
);

### tb/sv/slab_allocator_four_class_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the four-class slab allocator: a scoreboard class predicts
// every result, plain tasks drive the request and config channels. Depends on sla_pkg and sla_ifs.
module slab_allocator_four_class_tb import sla_pkg::*; ();

    localparam int MAX_POOL        = 65536;
    localparam int CHUNKS          = 512;
    localparam logic [9:0] NULL_LINK = 10'd512;
    localparam int ITEM_TARGET     = 1400;
    localparam int CALM_ITEMS      = 150;
    localparam int RSP_HOLD_CYCLES = 60;
    localparam int QUIET_LIMIT     = 20000;

    typedef struct packed {
        status_t     status;
        logic [31:0] caddr;
        logic [8:0]  cbytes;
    } slab_result_t;

    // Predicts allocator results from its own copy of the lists and layout, and checks responses.
    class slab_checker;
        logic [31:0]  base_reg;
        logic [16:0]  bytes_reg;
        logic [9:0]   heads[4];
        logic [9:0]   links[4*CHUNKS];
        bit           built;
        logic [31:0]  rsize;
        logic [31:0]  rstart[4];
        logic [31:0]  nchunks[4];
        slab_result_t pending_results[$];
        int errors, n_checked, n_built, n_handed, n_linked, n_refused;

        function new();
            base_reg  = '0;
            bytes_reg = '0;
            built     = 1'b0;
            rsize     = '0;
            for (int c = 0; c < 4; c++)
            begin
                heads[c]   = NULL_LINK;
                rstart[c]  = '0;
                nchunks[c] = '0;
            end
            errors = 0; n_checked = 0; n_built = 0;
            n_handed = 0; n_linked = 0; n_refused = 0;
        endfunction

        function logic [31:0] pad_bytes(logic [31:0] start);
            return (32'd8 - (start & 32'd7)) & 32'd7;
        endfunction

        function void write_reg(cfg_index_t idx, logic [31:0] value);
            if (idx == CFG_POOL_BASE)
                base_reg = value;
            else if (idx == CFG_POOL_BYTES)
                bytes_reg = value[16:0];
        endfunction

        // Cut the pool into four regions and chain each region's chunks, last one on top.
        function status_t build_lists();
            logic [31:0] used, rs, usable, n, start;
            used = (bytes_reg > MAX_POOL) ? MAX_POOL : 32'(bytes_reg);
            rs = used >> 2;
            if (rs < 32)
                return ST_NO_CHUNK;
            rsize = rs;
            for (int c = 0; c < 4; c++)
            begin
                start  = base_reg + c * rs;
                usable = rs - pad_bytes(start);
                n      = usable / (32 << c);
                if (n > CHUNKS)
                    n = CHUNKS;
                rstart[c]  = start;
                nchunks[c] = n;
                for (int k = 0; k < n; k++)
                    links[c*CHUNKS + k] = (k == 0) ? NULL_LINK : 10'(k - 1);
                heads[c] = (n == 0) ? NULL_LINK : 10'(n - 1);
            end
            built = 1'b1;
            return ST_OK;
        endfunction

        // First region, in class order, whose wrapped offset falls below the region size.
        function int find_region(logic [31:0] addr);
            logic [31:0] off;
            if (!built)
                return -1;
            for (int c = 0; c < 4; c++)
            begin
                off = addr - rstart[c];
                if (off < rsize)
                    return c;
            end
            return -1;
        endfunction

        // Work out the result of an accepted request and queue it.
        function slab_result_t note_request(req_type_t kind, logic [15:0] size,
                                            logic [31:0] addr);
            slab_result_t r;
            int cls;
            logic [31:0] off, pad, rel, cb, k;
            r.status = ST_OK;
            r.caddr  = '0;
            r.cbytes = '0;
            case (kind)
                REQ_INIT:
                begin
                    r.status = build_lists();
                    if (r.status == ST_OK)
                        n_built++;
                    else
                        n_refused++;
                end
                REQ_ALLOC:
                begin
                    cls = -1;
                    for (int c = 3; c >= 0; c--)
                        if (size <= (32 << c))
                            cls = c;
                    if (cls < 0 || heads[cls] >= NULL_LINK)
                    begin
                        r.status = ST_NO_CHUNK;
                        n_refused++;
                    end
                    else
                    begin
                        k = 32'(heads[cls]);
                        cb = 32 << cls;
                        r.caddr  = rstart[cls] + pad_bytes(rstart[cls]) + k * cb;
                        r.cbytes = cb[8:0];
                        heads[cls] = links[cls*CHUNKS + k];
                        n_handed++;
                    end
                end
                REQ_FREE:
                begin
                    cls = find_region(addr);
                    if (cls < 0)
                        r.status = ST_ADDR_REJECT;
                    else
                    begin
                        off = addr - rstart[cls];
                        pad = pad_bytes(rstart[cls]);
                        cb  = 32 << cls;
                        if (off < pad)
                            r.status = ST_ADDR_REJECT;
                        else
                        begin
                            rel = off - pad;
                            k   = rel / cb;
                            if ((rel % cb) != 0 || k >= nchunks[cls])
                                r.status = ST_ADDR_REJECT;
                            else
                            begin
                                links[cls*CHUNKS + k] = heads[cls];
                                heads[cls] = k[9:0];
                                n_linked++;
                            end
                        end
                    end
                    if (r.status != ST_OK)
                        n_refused++;
                end
                default:
                begin
                    cls = find_region(addr);
                    if (cls >= 0)
                        r.cbytes = 9'(32 << cls);
                end
            endcase
            pending_results.push_back(r);
            return r;
        endfunction

        task report_mismatch(string what);
            if (errors < 50)
                $display("[%0t] MISMATCH: %s", $time, what);
            errors++;
        endtask

        // Compare one response transfer, field by field, with the oldest prediction.
        task check_response(logic [1:0] st, logic [31:0] ca, logic [8:0] cbv);
            slab_result_t e;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result: status %0d addr %h bytes %0d",
                                          st, ca, cbv));
                return;
            end
            e = pending_results.pop_front();
            n_checked++;
            if (st !== e.status)
                report_mismatch($sformatf("result %0d status: got %0d, want %0d",
                                          n_checked, st, e.status));
            if (ca !== e.caddr)
                report_mismatch($sformatf("result %0d chunk_addr: got %h, want %h",
                                          n_checked, ca, e.caddr));
            if (cbv !== e.cbytes)
                report_mismatch($sformatf("result %0d chunk_bytes: got %0d, want %0d",
                                          n_checked, cbv, e.cbytes));
        endtask
    endclass

    logic clk;
    logic rst_n;
    sla_cfg_if cfg_bus();
    sla_req_if req_bus();
    sla_rsp_if rsp_bus();

    slab_checker chk;
    logic [31:0] live_chunks[$];
    int  items_sent;
    int  settings_used;
    bit  calm;
    bit  hold_rsp;
    int  quiet_cycles;

    slab_allocator_four_class i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // 20 ns clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Check every response transfer.
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            chk.check_response(rsp_bus.status, rsp_bus.chunk_addr, rsp_bus.chunk_bytes);
    end

    // Watchdog: end the run when no channel has moved a transfer for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[%0t] timeout: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Response side: random ready bursts, plus one long hold-off whenever asked.
    initial
    begin
        int n;
        rsp_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                hold_rsp = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Write one config register and mirror it in the scoreboard.
    task automatic cfg_write(cfg_index_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        chk.write_reg(idx, value);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Sender gap with valid low; its length is set by n.
    task automatic idle_req(int n);
        @(negedge clk);
        req_bus.valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Offer one request until it is taken, predict it, and track allocated chunks.
    task automatic send_req(req_type_t kind, logic [15:0] size, logic [31:0] addr);
        slab_result_t r;
        @(negedge clk);
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.req_size <= size;
        req_bus.req_addr <= addr;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        r = chk.note_request(kind, size, addr);
        items_sent++;
        if (kind == REQ_INIT && r.status == ST_OK)
            live_chunks.delete();
        if (kind == REQ_ALLOC && r.status == ST_OK)
            live_chunks.push_back(r.caddr);
        if (!calm && $urandom_range(0, 5) == 0)
            idle_req($urandom_range(1, 8));
    endtask

    // Stop offering and wait until every predicted result has been seen.
    task automatic drain_results();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (chk.pending_results.size() != 0) @(posedge clk);
    endtask

    // Address for a free or query: a live chunk, a chunk slot, a raw offset, or anything.
    function automatic logic [31:0] pick_addr(bit take);
        int mode, idx, c;
        logic [31:0] a, pad, cb;
        mode = $urandom_range(0, 9);
        if (mode < 5 && live_chunks.size() > 0)
        begin
            idx = $urandom_range(0, live_chunks.size() - 1);
            a = live_chunks[idx];
            // Leaving the chunk in the list now and then sets up a double free.
            if (take && $urandom_range(0, 9) != 0)
                live_chunks.delete(idx);
            return a;
        end
        if (mode == 9 || !chk.built)
            return $urandom();
        c   = $urandom_range(0, 3);
        cb  = 32 << c;
        pad = chk.pad_bytes(chk.rstart[c]);
        if (mode < 8)
        begin
            a = chk.rstart[c] + pad + $urandom_range(0, chk.nchunks[c] + 1) * cb;
            if ($urandom_range(0, 7) == 0)
                a = a + $urandom_range(1, cb - 1);
        end
        else
        begin
            a = chk.rstart[c] + $urandom_range(0, chk.rsize + 40) - 8;
        end
        return a;
    endfunction

    // Allocation size: mostly within the classes, some at class edges, some anything.
    function automatic logic [15:0] pick_size();
        logic [15:0] edges[9] = '{16'd0, 16'd32, 16'd33, 16'd64, 16'd65, 16'd128,
                                   16'd129, 16'd256, 16'd257};
        int r;
        r = $urandom_range(0, 19);
        if (r < 15)
            return 16'($urandom_range(0, 256));
        else if (r < 17)
            return edges[$urandom_range(0, 8)];
        else
            return 16'($urandom());
    endfunction

    function automatic logic [31:0] pick_base();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'hFFFF_FF00 + $urandom_range(0, 255);
            3: return $urandom() & 32'hFFFF_FFF8;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_bytes();
        case ($urandom_range(0, 15))
            0: return 32'd0;
            1: return 32'd127;
            2: return 32'd128;
            3: return 32'd65536;
            4: return 32'd131071;
            5: return $urandom() & 32'h1FFFF;
            default: return $urandom_range(128, 3000);
        endcase
    endfunction

    // One random request with a per-phase lean toward allocation.
    task automatic random_item(int alloc_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            send_req(REQ_INIT, 16'($urandom()), $urandom());
        else if (r < 2 + alloc_pct)
            send_req(REQ_ALLOC, pick_size(), $urandom());
        else if (r < 85)
            send_req(REQ_FREE, 16'($urandom()), pick_addr(1'b1));
        else
            send_req(REQ_QUERY, 16'($urandom()), pick_addr(1'b0));
    endtask

    initial
    begin
        int phase;
        int n_items;
        int alloc_pct;
        chk = new();
        items_sent    = 0;
        settings_used = 1;
        calm          = 1'b0;
        hold_rsp      = 1'b0;
        quiet_cycles  = 0;
        rst_n            = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.req_type = REQ_INIT;
        req_bus.req_size = '0;
        req_bus.req_addr = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = CFG_POOL_BASE;
        cfg_bus.data     = '0;

        // Hold reset, then release it.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Requests before any init, then an init on an empty pool.
        send_req(REQ_ALLOC, 16'd0, 32'd0);
        send_req(REQ_FREE, 16'd0, 32'd0);
        send_req(REQ_QUERY, 16'd0, 32'd0);
        send_req(REQ_INIT, 16'd0, 32'd0);

        // A pool whose regions come out one byte short of a chunk.
        drain_results();
        cfg_write(CFG_POOL_BASE, 32'h0000_1003);
        cfg_write(CFG_POOL_BYTES, 32'd127);
        send_req(REQ_INIT, 16'hFFFF, 32'hFFFF_FFFF);

        // Oversized, unaligned pool that wraps past address zero.
        drain_results();
        cfg_write(CFG_POOL_BASE, 32'hFFFF_F003);
        cfg_write(CFG_POOL_BYTES, 32'd131071);
        settings_used += 2;
        send_req(REQ_INIT, 16'd0, 32'd0);
        send_req(REQ_ALLOC, 16'd0, 32'd0);
        send_req(REQ_ALLOC, 16'd32, 32'd0);
        send_req(REQ_ALLOC, 16'd33, 32'd0);
        send_req(REQ_ALLOC, 16'd64, 32'd0);
        send_req(REQ_ALLOC, 16'd65, 32'd0);
        send_req(REQ_ALLOC, 16'd128, 32'd0);
        send_req(REQ_ALLOC, 16'd129, 32'd0);
        send_req(REQ_ALLOC, 16'd256, 32'd0);
        send_req(REQ_ALLOC, 16'd257, 32'd0);
        send_req(REQ_ALLOC, 16'hFFFF, 32'd0);
        // Free a chunk twice, then the misaligned, pad, past-the-end and outside cases.
        send_req(REQ_FREE, 16'd0, live_chunks[0]);
        send_req(REQ_FREE, 16'd0, live_chunks[0]);
        send_req(REQ_FREE, 16'd0, chk.rstart[1] + chk.pad_bytes(chk.rstart[1]) + 32'd65);
        send_req(REQ_FREE, 16'd0, chk.rstart[0]);
        send_req(REQ_FREE, 16'd0, chk.rstart[0] + chk.pad_bytes(chk.rstart[0])
                                  + chk.nchunks[0] * 32);
        send_req(REQ_FREE, 16'd0, chk.rstart[0] - 32'd1);
        send_req(REQ_QUERY, 16'd0, chk.rstart[2] + 32'd100);
        send_req(REQ_QUERY, 16'd0, chk.rstart[0] - 32'd1);
        send_req(REQ_ALLOC, 16'd16, 32'd0);

        // Random phases, each under a fresh pool setting.
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            drain_results();
            calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
            if ($urandom_range(0, 3) != 0)
                cfg_write(CFG_POOL_BASE, pick_base());
            if ($urandom_range(0, 3) != 0)
                cfg_write(CFG_POOL_BYTES, pick_bytes());
            settings_used++;
            // Usually rebuild at once; otherwise the new setting waits for a later init.
            if ($urandom_range(0, 4) != 0)
                send_req(REQ_INIT, 16'($urandom()), $urandom());
            if (!calm && phase % 4 == 1)
                hold_rsp = 1'b1;
            n_items   = $urandom_range(40, 160);
            alloc_pct = $urandom_range(30, 55);
            repeat (n_items)
                random_item(alloc_pct);
            phase++;
        end

        // Wind down and report.
        drain_results();
        repeat (20) @(posedge clk);
        $display("Ran %0d requests over %0d pool settings; %0d results checked.",
                 items_sent, settings_used, chk.n_checked);
        $display("Lists built %0d times, %0d chunks handed out, %0d frees linked, %0d refused.",
                 chk.n_built, chk.n_handed, chk.n_linked, chk.n_refused);
        if (chk.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
